// ===== rtl/chp_pkg.sv =====
// ---------------------------------------------------------------------------
// chp_pkg
// types and constants shared by the chunk header parser
// ---------------------------------------------------------------------------
`default_nettype none

package chp_pkg;

	localparam logic [5:0]  ID_MASK   = 6'h3F;
	localparam logic [16:0] ID_OFFSET = 17'd64;
	localparam logic [23:0] TIME_ESC  = 24'hFF_FFFF;

	localparam logic [1:0] FMT_FULL  = 2'd0;
	localparam logic [1:0] FMT_NOMSG = 2'd1;
	localparam logic [1:0] FMT_TIME  = 2'd2;
	localparam logic [1:0] FMT_NONE  = 2'd3;

	typedef enum logic [6:0] {
		PH_BASIC = 7'b000_0001,
		PH_ID    = 7'b000_0010,
		PH_TIME  = 7'b000_0100,
		PH_LEN   = 7'b000_1000,
		PH_KIND  = 7'b001_0000,
		PH_MSGCH = 7'b010_0000,
		PH_EXT   = 7'b100_0000
	} phase_t;

	typedef struct packed {
		logic [1:0]  header_format;
		logic [16:0] stream_channel;
		logic [23:0] time_value;
		logic [23:0] message_length;
		logic [7:0]  message_kind;
		logic [31:0] message_channel;
		logic [31:0] long_time;
		logic        long_time_read;
	} hdr_t;

endpackage

`default_nettype wire

// ===== rtl/chp_byte_if.sv =====
// ---------------------------------------------------------------------------
// chp_byte_if
// byte request channel into the chunk header parser
// ---------------------------------------------------------------------------
`default_nettype none

interface chp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/chp_hdr_if.sv =====
// ---------------------------------------------------------------------------
// chp_hdr_if
// parsed header request channel out of the chunk header parser
// ---------------------------------------------------------------------------
`default_nettype none

interface chp_hdr_if;
	logic        valid;
	logic        ready;
	logic [1:0]  header_format;
	logic [16:0] stream_channel;
	logic [23:0] time_value;
	logic [23:0] message_length;
	logic [7:0]  message_kind;
	logic [31:0] message_channel;
	logic [31:0] long_time;
	logic        long_time_read;

	modport source (
		output valid, output header_format, output stream_channel, output time_value,
		output message_length, output message_kind, output message_channel,
		output long_time, output long_time_read, input ready
	);
	modport sink (
		input valid, input header_format, input stream_channel, input time_value,
		input message_length, input message_kind, input message_channel,
		input long_time, input long_time_read, output ready
	);
endinterface

`default_nettype wire

// ===== rtl/chunk_header_parser.sv =====
// ---------------------------------------------------------------------------
// chunk_header_parser
// byte-serial parser for streaming chunk headers
// ---------------------------------------------------------------------------
// Takes one header byte per cycle unless the output stalls, and gives one
// parsed header request on the byte that completes a header; fields a short
// format leaves out keep their earlier values. Each byte passes an input
// register, then the parse state machine updates and any finished header is
// written to the result register, which drives the output channel. With the
// output stalled, one more byte is taken into the input register before
// input stalls.
`default_nettype none

module chunk_header_parser
	import chp_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	chp_byte_if.sink  byte_in,
	chp_hdr_if.source hdr_out
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       can_load;
	logic       advance;
	logic       fire;
	hdr_t       result;

	assign advance       = valid_s1 && can_load;
	assign byte_in.ready = !valid_s1 || can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_in.ready) begin
			valid_s1 <= byte_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_in.valid && byte_in.ready) begin
			byte_s1 <= byte_in.data_byte;
		end
	end

	chp_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.byte_s1 (byte_s1),
		.fire    (fire),
		.result  (result)
	);

	chp_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance && fire),
		.d        (result),
		.can_load (can_load),
		.hdr_out  (hdr_out)
	);

endmodule

`default_nettype wire

// ===== rtl/chp_parse.sv =====
// ---------------------------------------------------------------------------
// chp_parse
// parse state machine and held header fields, one byte per advance
// ---------------------------------------------------------------------------
`default_nettype none

module chp_parse
	import chp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       advance,
	input  wire logic [7:0] byte_s1,
	output logic            fire,
	output hdr_t            result
);

	phase_t      state_q, state_nxt;
	logic [2:0]  left_q, left_nxt;
	logic [1:0]  fmt_q, fmt_nxt;
	logic [16:0] chan_q, chan_nxt;
	logic [23:0] time_q, time_nxt;
	logic [23:0] len_q, len_nxt;
	logic [7:0]  kind_q, kind_nxt;
	logic [31:0] mch_q, mch_nxt;
	logic [31:0] lt_q, lt_nxt;
	logic        got_q, got_nxt;

	always_comb begin
		logic [2:0]  dec;
		logic        check_ext;
		logic        start_fields;
		dec          = left_q - 3'd1;
		state_nxt    = state_q;
		left_nxt     = left_q;
		fmt_nxt      = fmt_q;
		chan_nxt     = chan_q;
		time_nxt     = time_q;
		len_nxt      = len_q;
		kind_nxt     = kind_q;
		mch_nxt      = mch_q;
		lt_nxt       = lt_q;
		got_nxt      = got_q;
		fire         = 1'b0;
		check_ext    = 1'b0;
		start_fields = 1'b0;
		case (state_q)
			PH_ID: begin
				left_nxt = dec;
				if (dec == 3'd0) begin
					chan_nxt     = 17'({chan_q[7:0], byte_s1}) + ID_OFFSET;
					start_fields = 1'b1;
				end else begin
					chan_nxt = 17'({chan_q[7:0], byte_s1});
				end
			end
			PH_TIME: begin
				time_nxt = {time_q[15:0], byte_s1};
				left_nxt = dec;
				if (dec == 3'd0) begin
					if (fmt_q == FMT_TIME) begin
						check_ext = 1'b1;
					end else begin
						state_nxt = PH_LEN;
						left_nxt  = 3'd3;
					end
				end
			end
			PH_LEN: begin
				len_nxt  = {len_q[15:0], byte_s1};
				left_nxt = dec;
				if (dec == 3'd0) begin
					state_nxt = PH_KIND;
					left_nxt  = 3'd1;
				end
			end
			PH_KIND: begin
				kind_nxt = byte_s1;
				if (fmt_q == FMT_NOMSG) begin
					check_ext = 1'b1;
				end else begin
					state_nxt = PH_MSGCH;
					left_nxt  = 3'd4;
				end
			end
			PH_MSGCH: begin
				mch_nxt  = {mch_q[23:0], byte_s1};
				left_nxt = dec;
				if (dec == 3'd0) begin
					check_ext = 1'b1;
				end
			end
			PH_EXT: begin
				lt_nxt   = {lt_q[23:0], byte_s1};
				left_nxt = dec;
				if (dec == 3'd0) begin
					got_nxt   = 1'b1;
					fire      = 1'b1;
					state_nxt = PH_BASIC;
				end
			end
			default: begin
				fmt_nxt = byte_s1[7:6];
				got_nxt = 1'b0;
				if ((byte_s1[5:0] & ID_MASK) <= 6'd1) begin
					chan_nxt  = '0;
					state_nxt = PH_ID;
					left_nxt  = byte_s1[0] ? 3'd2 : 3'd1;
				end else begin
					chan_nxt     = 17'(byte_s1[5:0] & ID_MASK);
					start_fields = 1'b1;
				end
			end
		endcase
		if (start_fields) begin
			if (fmt_nxt == FMT_NONE) begin
				check_ext = 1'b1;
			end else begin
				state_nxt = PH_TIME;
				left_nxt  = 3'd3;
			end
		end
		if (check_ext) begin
			if (time_nxt == TIME_ESC) begin
				state_nxt = PH_EXT;
				left_nxt  = 3'd4;
			end else begin
				fire      = 1'b1;
				state_nxt = PH_BASIC;
			end
		end
		if (fire) begin
			left_nxt = 3'd0;
		end
	end

	assign result = '{
		header_format:   fmt_nxt,
		stream_channel:  chan_nxt,
		time_value:      time_nxt,
		message_length:  len_nxt,
		message_kind:    kind_nxt,
		message_channel: mch_nxt,
		long_time:       lt_nxt,
		long_time_read:  got_nxt
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PH_BASIC;
			left_q  <= '0;
			fmt_q   <= '0;
			chan_q  <= '0;
			time_q  <= '0;
			len_q   <= '0;
			kind_q  <= '0;
			mch_q   <= '0;
			lt_q    <= '0;
			got_q   <= 1'b0;
		end else if (advance) begin
			state_q <= state_nxt;
			left_q  <= left_nxt;
			fmt_q   <= fmt_nxt;
			chan_q  <= chan_nxt;
			time_q  <= time_nxt;
			len_q   <= len_nxt;
			kind_q  <= kind_nxt;
			mch_q   <= mch_nxt;
			lt_q    <= lt_nxt;
			got_q   <= got_nxt;
		end
	end

`ifndef NO_ASSERTIONS
	a_fire_returns_basic: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && fire) |=> (state_q == PH_BASIC && left_q == 3'd0))
		else $error("parser not back at basic header after result");

	a_ext_last_fires: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && state_q == PH_EXT && left_q == 3'd1) |-> (fire && result.long_time_read))
		else $error("last extended timestamp byte gave no result");

	a_counted_phase_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == PH_TIME || state_q == PH_LEN || state_q == PH_MSGCH
			|| state_q == PH_EXT || state_q == PH_ID) |-> (left_q != 3'd0))
		else $error("byte count empty in a counted phase");
`endif

endmodule

`default_nettype wire

// ===== rtl/chp_out_reg.sv =====
// ---------------------------------------------------------------------------
// chp_out_reg
// result register driving the header output channel
// ---------------------------------------------------------------------------
`default_nettype none

module chp_out_reg
	import chp_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  load,
	input  wire hdr_t  d,
	output logic       can_load,
	chp_hdr_if.source  hdr_out
);

	logic valid_q;
	hdr_t data_q;

	assign can_load = !valid_q || hdr_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (hdr_out.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= d;
		end
	end

	assign hdr_out.valid           = valid_q;
	assign hdr_out.header_format   = data_q.header_format;
	assign hdr_out.stream_channel  = data_q.stream_channel;
	assign hdr_out.time_value      = data_q.time_value;
	assign hdr_out.message_length  = data_q.message_length;
	assign hdr_out.message_kind    = data_q.message_kind;
	assign hdr_out.message_channel = data_q.message_channel;
	assign hdr_out.long_time       = data_q.long_time;
	assign hdr_out.long_time_read  = data_q.long_time_read;

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// self-checking bench for chunk_header_parser
// ---------------------------------------------------------------------------
// Feeds header bytes through the byte channel and compares every parsed header
// request with a header from a short table of directed bytes, which comes
// first, or else from a behavioral parser kept in the bench. Then come random
// byte streams, mostly well-formed headers with random content and some stray
// bytes, under several mixes of sender idling and receiver stalls.

module tb;
	import chp_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic       typed;
		hdr_t       hdr;
	} step_row_t;

	logic clk = 1'b0;
	logic arst_n;

	chp_byte_if byte_ch ();
	chp_hdr_if  hdr_ch ();

	chunk_header_parser DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_in (byte_ch),
		.hdr_out (hdr_ch)
	);

	always #5 clk = ~clk;

	// parser state mirrored in the bench
	phase_t     ph;
	logic [2:0] left;
	hdr_t       held;
	bit         want_esc;

	hdr_t      expected_hdrs[$];
	step_row_t dir_rows[$];
	int        mismatches = 0;
	int        idle_pct = 0;
	int        stall_pct = 0;

	function automatic bit parse_byte(input logic [7:0] b, output hdr_t hdr);
		bit to_fields = 1'b0;
		bit to_esc_check = 1'b0;
		bit complete = 1'b0;
		hdr = '0;
		case (ph)
			PH_ID: begin
				held.stream_channel = {1'b0, held.stream_channel[7:0], b};
				left = left - 3'd1;
				if (left == 3'd0) begin
					held.stream_channel = held.stream_channel + ID_OFFSET;
					to_fields = 1'b1;
				end
			end
			PH_TIME: begin
				held.time_value = {held.time_value[15:0], b};
				left = left - 3'd1;
				if (left == 3'd0) begin
					if (held.header_format == FMT_TIME) begin
						to_esc_check = 1'b1;
					end else begin
						ph = PH_LEN;
						left = 3'd3;
					end
				end
			end
			PH_LEN: begin
				held.message_length = {held.message_length[15:0], b};
				left = left - 3'd1;
				if (left == 3'd0) begin
					ph = PH_KIND;
					left = 3'd1;
				end
			end
			PH_KIND: begin
				held.message_kind = b;
				if (held.header_format == FMT_NOMSG) begin
					to_esc_check = 1'b1;
				end else begin
					ph = PH_MSGCH;
					left = 3'd4;
				end
			end
			PH_MSGCH: begin
				held.message_channel = {held.message_channel[23:0], b};
				left = left - 3'd1;
				if (left == 3'd0)
					to_esc_check = 1'b1;
			end
			PH_EXT: begin
				held.long_time = {held.long_time[23:0], b};
				left = left - 3'd1;
				if (left == 3'd0) begin
					held.long_time_read = 1'b1;
					complete = 1'b1;
				end
			end
			default: begin
				held.header_format = b[7:6];
				held.long_time_read = 1'b0;
				if (b[5:0] <= 6'd1) begin
					held.stream_channel = '0;
					ph = PH_ID;
					left = {2'b00, b[0]} + 3'd1;
				end else begin
					held.stream_channel = {11'd0, b[5:0] & ID_MASK};
					to_fields = 1'b1;
				end
			end
		endcase
		if (to_fields) begin
			if (held.header_format == FMT_NONE) begin
				to_esc_check = 1'b1;
			end else begin
				ph = PH_TIME;
				left = 3'd3;
			end
		end
		if (to_esc_check) begin
			if (held.time_value == TIME_ESC) begin
				ph = PH_EXT;
				left = 3'd4;
			end else begin
				complete = 1'b1;
			end
		end
		if (complete) begin
			hdr = held;
			ph = PH_BASIC;
			left = 3'd0;
		end
		return complete;
	endfunction

	// mostly well-formed headers, one byte in ten is a stray byte
	function automatic logic [7:0] pick_byte();
		logic [7:0] b;
		b = 8'($urandom_range(255));
		if ($urandom_range(9) == 0)
			return b;
		case (ph)
			PH_BASIC: begin
				want_esc = ($urandom_range(3) == 0);
				case ($urandom_range(5))
					0: b[5:0] = 6'd0;
					1: b[5:0] = 6'd1;
					2: b[5:0] = ID_MASK;
					default: b[5:0] = 6'($urandom_range(63, 2));
				endcase
			end
			PH_TIME: begin
				if (want_esc)
					b = 8'hFF;
			end
			default: begin
				if ($urandom_range(7) == 0)
					b = $urandom_range(1) ? 8'hFF : 8'h00;
			end
		endcase
		return b;
	endfunction

	function automatic hdr_t mk_hdr(input logic [1:0] fmt, input logic [16:0] chan,
			input logic [23:0] tval, input logic [23:0] len, input logic [7:0] kind,
			input logic [31:0] mchan, input logic [31:0] ltime, input logic lread);
		hdr_t h;
		h.header_format = fmt;
		h.stream_channel = chan;
		h.time_value = tval;
		h.message_length = len;
		h.message_kind = kind;
		h.message_channel = mchan;
		h.long_time = ltime;
		h.long_time_read = lread;
		return h;
	endfunction

	function automatic void plain(input logic [7:0] b);
		dir_rows.push_back({b, 1'b0, hdr_t'('0)});
	endfunction

	function automatic void ends(input logic [7:0] b, input hdr_t h);
		dir_rows.push_back({b, 1'b1, h});
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic typed, input hdr_t typed_hdr);
		hdr_t h;
		while ($urandom_range(99) < idle_pct) begin
			byte_ch.valid <= 1'b0;
			@(posedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.data_byte <= b;
		@(posedge clk);
		while (!byte_ch.ready)
			@(posedge clk);
		if (parse_byte(b, h))
			expected_hdrs.push_back(typed ? typed_hdr : h);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		hdr_t want;
		if (arst_n) begin
			if (hdr_ch.valid && hdr_ch.ready) begin
				if (expected_hdrs.size() == 0) begin
					$error("header request with none expected");
					mismatches++;
				end else begin
					want = expected_hdrs.pop_front();
					check_field("header_format", 32'(want.header_format),
						32'(hdr_ch.header_format));
					check_field("stream_channel", 32'(want.stream_channel),
						32'(hdr_ch.stream_channel));
					check_field("time_value", 32'(want.time_value), 32'(hdr_ch.time_value));
					check_field("message_length", 32'(want.message_length),
						32'(hdr_ch.message_length));
					check_field("message_kind", 32'(want.message_kind),
						32'(hdr_ch.message_kind));
					check_field("message_channel", want.message_channel,
						hdr_ch.message_channel);
					check_field("long_time", want.long_time, hdr_ch.long_time);
					check_field("long_time_read", 32'(want.long_time_read),
						32'(hdr_ch.long_time_read));
				end
			end
			hdr_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	initial begin
		int idle_tab[4];
		int stall_tab[4];
		idle_tab = '{0, 55, 0, 25};
		stall_tab = '{0, 0, 55, 25};
		arst_n = 1'b0;
		byte_ch.valid = 1'b0;
		byte_ch.data_byte = 8'h00;
		hdr_ch.ready = 1'b0;
		ph = PH_BASIC;
		left = 3'd0;
		held = '0;
		want_esc = 1'b0;

		// short format 3 header right after reset reports zero fields
		ends(8'hC2, mk_hdr(FMT_NONE, 17'd2, '0, '0, '0, '0, '0, 1'b0));
		// two-byte id at its largest
		plain(8'hC1);
		plain(8'hFF);
		ends(8'hFF, mk_hdr(FMT_NONE, 17'd65599, '0, '0, '0, '0, '0, 1'b0));
		// full header, one-byte id, escape timestamp and extended timestamp
		plain(8'h00);
		plain(8'h00);
		plain(8'hFF);
		plain(8'hFF);
		plain(8'hFF);
		plain(8'h00);
		plain(8'h00);
		plain(8'h00);
		plain(8'hFF);
		plain(8'hFF);
		plain(8'hFF);
		plain(8'hFF);
		plain(8'hFF);
		plain(8'h00);
		plain(8'h00);
		plain(8'h00);
		ends(8'h01, mk_hdr(FMT_FULL, 17'd64, TIME_ESC, '0, 8'hFF, 32'hFFFF_FFFF,
			32'h0000_0001, 1'b1));
		// format 3 with the held escape timestamp
		plain(8'hFF);
		plain(8'hFF);
		plain(8'hFF);
		plain(8'hFF);
		ends(8'hFF, mk_hdr(FMT_NONE, 17'd63, TIME_ESC, '0, 8'hFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 1'b1));
		// format 2 clears the escape
		plain(8'h82);
		plain(8'h00);
		plain(8'h00);
		ends(8'h00, mk_hdr(FMT_TIME, 17'd2, '0, '0, 8'hFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 1'b0));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_byte(dir_rows[i].data, dir_rows[i].typed, dir_rows[i].hdr);

		for (int p = 0; p < 4; p++) begin
			idle_pct = idle_tab[p];
			stall_pct = stall_tab[p];
			for (int i = 0; i < 150; i++)
				send_byte(pick_byte(), 1'b0, '0);
			// hold off until the parser has drained
			byte_ch.valid <= 1'b0;
			do @(posedge clk); while (expected_hdrs.size() != 0);
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0 && expected_hdrs.size() == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("tb: done, errors");
		$finish;
	end

endmodule
